@@ rtl/core/utf8v_pkg.sv @@
// Package: shared types, constants and helpers for the UTF-8 stream validator.
`timescale 1ns / 1ps
`default_nettype none

package utf8v_pkg;

  // Lead byte ranges
  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD3_LO = 8'he0;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD4_LO = 8'hf0;
  localparam logic [7:0] LEAD4_HI = 8'hf4;

  // Continuation byte form 10xxxxxx
  localparam logic [7:0] CONT_MASK = 8'hc0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // Code point limits
  localparam logic [20:0] CP_MAX      = 21'h10ffff;
  localparam logic [20:0] SURR_LO     = 21'h00d800;
  localparam logic [20:0] SURR_HI     = 21'h00dfff;
  localparam logic [20:0] MIN_CLASS1  = 21'h000080;
  localparam logic [20:0] MIN_CLASS2  = 21'h000800;
  localparam logic [20:0] MIN_CLASS3  = 21'h010000;

  // Sequence length classes
  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_TWO  = 2'd1;
  localparam logic [1:0] CLASS_THREE = 2'd2;
  localparam logic [1:0] CLASS_FOUR = 2'd3;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [1:0]  bytes_left;
    logic [20:0] code_value;
    logic [1:0]  length_class;
    logic        error_seen;
  } dec_state_t;

  localparam dec_state_t DEC_STATE_RESET = '{
    bytes_left:   2'd0,
    code_value:   21'd0,
    length_class: CLASS_NONE,
    error_seen:   1'b0
  };

  // Smallest code point a sequence of the given class may encode
  function automatic logic [20:0] class_minimum(input logic [1:0] cls);
    logic [20:0] m;
    case (cls)
      CLASS_TWO:   m = MIN_CLASS1;
      CLASS_THREE: m = MIN_CLASS2;
      default:     m = MIN_CLASS3;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/utf8v_step.sv @@
// Combinational next-state and verdict logic for one byte of the stream.
`timescale 1ns / 1ps
`default_nettype none

module utf8v_step import utf8v_pkg::*; (
  input  dec_state_t  cur,
  input  logic [7:0]  data_byte,
  input  logic        end_of_text,
  output dec_state_t  nxt,
  output logic        still_valid
);

  dec_state_t  taken;
  logic [20:0] shifted;
  logic [1:0]  left_dec;

  assign shifted  = {cur.code_value[14:0], data_byte[5:0]};
  assign left_dec = cur.bytes_left - 2'd1;

  // Decode the byte against the current sequence state
  always_comb begin
    taken = cur;
    if (cur.error_seen) begin
      taken = cur;
    end else if (cur.bytes_left == 2'd0) begin
      if (data_byte < CONT_TAG) begin
        if (data_byte == 8'd0) begin
          taken = DEC_STATE_RESET;
          taken.error_seen = 1'b1;
        end
      end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
        taken.bytes_left   = 2'd1;
        taken.length_class = CLASS_TWO;
        taken.code_value   = {16'd0, data_byte[4:0]};
      end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
        taken.bytes_left   = 2'd2;
        taken.length_class = CLASS_THREE;
        taken.code_value   = {17'd0, data_byte[3:0]};
      end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
        taken.bytes_left   = 2'd3;
        taken.length_class = CLASS_FOUR;
        taken.code_value   = {18'd0, data_byte[2:0]};
      end else begin
        taken = DEC_STATE_RESET;
        taken.error_seen = 1'b1;
      end
    end else if ((data_byte & CONT_MASK) != CONT_TAG) begin
      taken = DEC_STATE_RESET;
      taken.error_seen = 1'b1;
    end else begin
      taken.code_value = shifted;
      taken.bytes_left = left_dec;
      // Check the finished code point for overlong, range and surrogates
      if (left_dec == 2'd0) begin
        if (shifted < class_minimum(cur.length_class) || shifted > CP_MAX ||
            (shifted >= SURR_LO && shifted <= SURR_HI)) begin
          taken = DEC_STATE_RESET;
          taken.error_seen = 1'b1;
        end else begin
          taken.code_value   = 21'd0;
          taken.length_class = CLASS_NONE;
        end
      end
    end
  end

  // Close the text on its final byte: flag truncation, then clear state
  always_comb begin
    if (end_of_text) begin
      still_valid = !taken.error_seen && (taken.bytes_left == 2'd0);
      nxt         = DEC_STATE_RESET;
    end else begin
      still_valid = !taken.error_seen;
      nxt         = taken;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/utf8_stream_validator_core.sv @@
// Top level: input register, byte decoder, decoder state and result register.
// A byte passes through the input register, then the result register, to its result.
// Throughput: one byte per cycle when not stalled; the state loop holds one register.
// A stalled result holds the input register; the input stalls only when both
// stages are full. Reset is synchronous, active high: it empties both stages
// and returns the decoder state to the start of a text.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_validator_core import utf8v_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       still_valid,
  output logic       verdict_final
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_last;
  logic       advance;

  dec_state_t state;
  dec_state_t state_next;
  logic       valid_next;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = hold_valid && !advance;

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_byte <= data_byte;
      hold_last <= end_of_text;
    end
  end

  utf8v_step u_step (
    .cur         (state),
    .data_byte   (hold_byte),
    .end_of_text (hold_last),
    .nxt         (state_next),
    .still_valid (valid_next)
  );

  // Advance the decoder state as each byte moves to the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DEC_STATE_RESET;
    end else if (hold_valid && advance) begin
      state <= state_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_valid && advance) begin
      still_valid   <= valid_next;
      verdict_final <= hold_last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/utf8v_checker.sv @@
// Port-level checker for the UTF-8 stream validator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module utf8v_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic still_valid,
  input logic verdict_final
);

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result valid or input stalled after reset");

  // Input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(still_valid)
      && $stable(verdict_final))
    else $error("stalled result changed");

  // An error stays until the end of the text
  a_sticky_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !still_valid && !verdict_final
      |=> !out_valid || !still_valid)
    else $error("error cleared before end of text");

endmodule

bind utf8_stream_validator_core utf8v_checker u_utf8v_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .still_valid   (still_valid),
  .verdict_final (verdict_final)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for the UTF-8 stream validator: directed and random texts, scored per byte.
`timescale 1ns / 1ps

module testbench;
  import utf8v_pkg::*;

  localparam int  RUN_LIMIT      = 200000;
  localparam int  DRAIN_CYCLES   = 10;
  localparam int  HOLDOFF_CYCLES = 300;
  localparam int  PHASE_BYTES    = 250;
  localparam int  MAX_PRINTS     = 50;
  localparam logic [7:0] NUL_BYTE = 8'h00;

  typedef enum int {
    PH_STEADY,
    PH_SLOW_SEND,
    PH_SLOW_RECV,
    PH_BOTH_SLOW,
    PH_BACKPRESSURE
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_item_t;

  typedef struct packed {
    logic still_valid;
    logic verdict_final;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       still_valid;
  logic       verdict_final;

  text_item_t byte_q[$];
  verdict_t   verdict_q[$];
  logic [7:0] text_buf[$];
  text_item_t next_item;
  verdict_t   got_verdict;
  verdict_t   want_verdict;
  dec_state_t decoder = DEC_STATE_RESET;

  phase_e phase = PH_STEADY;
  int     idle_pct = 0;
  int     stall_pct = 0;
  logic   hold_on = 1'b0;
  int     error_count = 0;
  int     cycle_count = 0;

  utf8_stream_validator_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_text   (end_of_text),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .still_valid   (still_valid),
    .verdict_final (verdict_final)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    end
    error_count++;
  endtask

  // Mark the decoder as failed; the partial sequence is dropped.
  function automatic void mark_invalid();
    decoder.error_seen   = 1'b1;
    decoder.bytes_left   = 2'd0;
    decoder.code_value   = 21'd0;
    decoder.length_class = CLASS_NONE;
  endfunction

  // Advance the decoder by one byte and return the verdict so far.
  function automatic logic decode_byte(input logic [7:0] b, input logic last);
    logic [20:0] cp;
    logic [20:0] floor_cp;
    logic        ok;
    if (!decoder.error_seen) begin
      if (decoder.bytes_left == 2'd0) begin
        if (b < CONT_TAG) begin
          if (b == NUL_BYTE) mark_invalid();
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
          decoder.bytes_left   = 2'd1;
          decoder.length_class = CLASS_TWO;
          decoder.code_value   = {16'd0, b[4:0]};
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
          decoder.bytes_left   = 2'd2;
          decoder.length_class = CLASS_THREE;
          decoder.code_value   = {17'd0, b[3:0]};
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
          decoder.bytes_left   = 2'd3;
          decoder.length_class = CLASS_FOUR;
          decoder.code_value   = {18'd0, b[2:0]};
        end else begin
          mark_invalid();
        end
      end else if ((b & CONT_MASK) != CONT_TAG) begin
        mark_invalid();
      end else begin
        cp = {decoder.code_value[14:0], b[5:0]};
        decoder.code_value = cp;
        decoder.bytes_left = decoder.bytes_left - 2'd1;
        if (decoder.bytes_left == 2'd0) begin
          // Reject overlong forms, out-of-range values and surrogates
          case (decoder.length_class)
            CLASS_TWO:   floor_cp = MIN_CLASS1;
            CLASS_THREE: floor_cp = MIN_CLASS2;
            default:     floor_cp = MIN_CLASS3;
          endcase
          if (cp < floor_cp || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
            mark_invalid();
          end else begin
            decoder.code_value   = 21'd0;
            decoder.length_class = CLASS_NONE;
          end
        end
      end
    end
    // A sequence cut short by the end of text fails the text
    if (last && decoder.bytes_left != 2'd0) mark_invalid();
    ok = !decoder.error_seen;
    if (last) decoder = DEC_STATE_RESET;
    return ok;
  endfunction

  // Add one byte to the end of the text under construction.
  function automatic void append_byte(input logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endfunction

  // Append one character in the given byte count, using the low code point bits.
  task automatic encode_char(input logic [20:0] cp, input int nbytes);
    case (nbytes)
      1: append_byte({1'b0, cp[6:0]});
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte({2'b10, cp[5:0]});
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte({2'b10, cp[17:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Move the text in the buffer to the send queue, marking its last byte.
  task automatic flush_text(output int count);
    text_item_t item;
    count = text_buf.size();
    for (int i = 0; i < count; i++) begin
      item.data = text_buf[i];
      item.last = (i == count - 1);
      byte_q.insert(byte_q.size(), item);
    end
    text_buf.delete();
  endtask

  // Build one random text: mostly well-formed, some corrupted or pure noise.
  task automatic add_random_text(output int count);
    int          n_chars;
    int          mode;
    int          nb;
    logic [20:0] cp;
    n_chars = $urandom_range(1, 8);
    mode = $urandom_range(0, 9);
    if (mode == 9) begin
      for (int i = 0; i < n_chars; i++) append_byte(8'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < n_chars; i++) begin
        nb = $urandom_range(1, 4);
        case (nb)
          1: cp = 21'($urandom_range(1, 'h7f));
          2: cp = 21'($urandom_range('h80, 'h7ff));
          3: begin
            cp = 21'($urandom_range('h800, 'hffff));
            if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h2000;
          end
          default: cp = 21'($urandom_range('h10000, 'h10ffff));
        endcase
        encode_char(cp, nb);
      end
      case (mode)
        6: text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
        7: begin
          // Cut the last character short
          nb = $urandom_range(2, 4);
          encode_char(21'($urandom_range(0, 'h1fffff)), nb);
          for (int i = $urandom_range(1, nb - 1); i > 0; i--) void'(text_buf.pop_back());
        end
        8: encode_char(21'($urandom_range(0, 'h1fffff)), $urandom_range(2, 4));
        default: ;
      endcase
    end
    flush_text(count);
  endtask

  // Wait until every queued byte is sent and every verdict has come back.
  // Sample on the falling edge so the driver and monitor updates have settled.
  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
  endtask

  // Drive bytes and predict the verdict of each transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        want_verdict.still_valid   = decode_byte(data_byte, end_of_text);
        want_verdict.verdict_final = end_of_text;
        verdict_q.insert(verdict_q.size(), want_verdict);
      end
      if (!in_valid || !in_stall) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          next_item = byte_q.pop_front();
          in_valid    <= 1'b1;
          data_byte   <= next_item.data;
          end_of_text <= next_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Score each result transfer and choose the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result with none expected (still_valid=%0b final=%0b)",
                                  still_valid, verdict_final));
      end else begin
        got_verdict = verdict_q.pop_front();
        if (still_valid !== got_verdict.still_valid) begin
          report_mismatch($sformatf("still_valid %0b, expected %0b",
                                    still_valid, got_verdict.still_valid));
        end
        if (verdict_final !== got_verdict.verdict_final) begin
          report_mismatch($sformatf("verdict_final %0b, expected %0b",
                                    verdict_final, got_verdict.verdict_final));
        end
      end
    end
    out_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);
  end

  // Hold the result side off for a long stretch so the input backs up
  initial begin
    while (phase != PH_BACKPRESSURE) @(posedge clk);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int added;
    int phase_total;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed texts: valid extremes, NUL, invalid leads, overlong, surrogate,
    // above the code point limit, bad continuation, truncated sequence
    text_buf = '{8'h41, 8'hc2, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
    flush_text(added);
    text_buf = '{NUL_BYTE};
    flush_text(added);
    text_buf = '{8'hc1, 8'h41};
    flush_text(added);
    text_buf = '{8'he0, 8'h80, 8'h80};
    flush_text(added);
    text_buf = '{8'hed, 8'ha0, 8'h80};
    flush_text(added);
    text_buf = '{8'hf4, 8'h90, 8'h80, 8'h80};
    flush_text(added);
    text_buf = '{8'hc3, 8'h41};
    flush_text(added);
    text_buf = '{8'he2, 8'h82};
    flush_text(added);
    text_buf = '{8'hff};
    flush_text(added);
    wait_drained();

    // Random texts under each idling pattern
    for (int p = PH_STEADY; p <= PH_BACKPRESSURE; p++) begin
      phase <= phase_e'(p);
      case (phase_e'(p))
        PH_SLOW_SEND: begin idle_pct <= 75; stall_pct <= 0;  end
        PH_SLOW_RECV: begin idle_pct <= 0;  stall_pct <= 75; end
        PH_BOTH_SLOW: begin idle_pct <= 17; stall_pct <= 17; end
        default:      begin idle_pct <= 0;  stall_pct <= 0;  end
      endcase
      @(posedge clk);
      phase_total = 0;
      while (phase_total < PHASE_BYTES) begin
        add_random_text(added);
        phase_total += added;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
